### rtl/psbf_pkg.sv
// Shared constants and payload types of the particle spread block.
`timescale 1ns / 1ps
package psbf_pkg;

	localparam int MAX_PARTICLES = 1024;
	localparam int ADDR_W        = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
	localparam int POS_W         = 32;
	localparam int QUAT_W        = 16;
	localparam int SUM_W         = POS_W + CNT_W - 1;
	localparam int OUT_W         = 31;
	localparam int MAT_W         = 27;
	localparam int DEN_W         = CNT_W + 16;
	localparam int DIV_W         = 64;
	localparam int SQ_W          = 48;
	localparam logic [OUT_W-1:0] VAR_FLOOR = OUT_W'(7);
	localparam logic [OUT_W-1:0] VAR_SAT   = {OUT_W{1'b1}};

	typedef struct packed {
		logic                     particle_valid;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic                     batch_last;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] std_x;
		logic [OUT_W-1:0] std_y;
		logic [OUT_W-1:0] std_z;
		logic [OUT_W-1:0] var_x;
		logic [OUT_W-1:0] var_y;
		logic [OUT_W-1:0] var_z;
		logic [CNT_W-1:0] particle_count;
		logic             overflow;
	} result_t;

endpackage

### rtl/psbf_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module psbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### rtl/particle_spread_in_body_frame.sv
// Top level: particle batch store, mean, body-frame spread and standard deviation.
`timescale 1ns / 1ps
//
// Channel   Signals                            Moves
// ------    -------------------------------    --------------------------------------
// item      item_valid / item_ready / item     one particle slot, quaternion, last flag
// result    result_valid / result_ready / result  stds, variances, count, overflow
//
// Particle items load back to back into the store. The item marked last starts the
// batch math: three 64-step mean divisions, a read pass over the store at one
// particle per cycle and a drain of the pass pipeline, then per axis a
// 64-step variance division and a 24-step square root.
// All divisions share the restoring divider, and the store has a single port.
// Reset clears control state and batch sums; the store needs no clearing.
// The result register holds a finished item while loading of the next batch goes on.
module particle_spread_in_body_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  psbf_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output psbf_pkg::result_t result
);
	import psbf_pkg::*;

	typedef enum logic [11:0] {
		S_LOAD  = 12'b0000_0000_0001,
		S_MSET  = 12'b0000_0000_0010,
		S_MEAN  = 12'b0000_0000_0100,
		S_MFIN  = 12'b0000_0000_1000,
		S_PASS  = 12'b0000_0001_0000,
		S_DRAIN = 12'b0000_0010_0000,
		S_VSET  = 12'b0000_0100_0000,
		S_VAR   = 12'b0000_1000_0000,
		S_VFIN  = 12'b0001_0000_0000,
		S_SQRT  = 12'b0010_0000_0000,
		S_SFIN  = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// batch accumulation
	logic [CNT_W-1:0]        count_q, cnt_nxt, n_q;
	logic                    dropped_q, ovf_q;
	logic signed [SUM_W-1:0] sum_q [3];

	// reference orientation and the conjugate rotation matrix
	logic signed [QUAT_W-1:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0]       prod_q [9];
	logic signed [34:0]       mraw   [9];
	logic signed [MAT_W-1:0]  mat_q  [9];

	// shared restoring divider
	logic [1:0]              ax_q;
	logic [DIV_W-1:0]        div_num_q;
	logic [DEN_W-1:0]        div_rem_q, div_den_q;
	logic [5:0]              div_cnt_q;
	logic                    div_neg_q;
	logic [DEN_W+1:0]        div_trial;
	logic                    div_ge;
	logic signed [SUM_W+1:0] mean_num;
	logic [SUM_W+1:0]        mean_mag;

	logic signed [POS_W-1:0] mean_q [3];

	// second pass pipeline
	logic [CNT_W-1:0]         rd_addr_q;
	logic                     rd_v_q, v_s2, v_s3, v_s4, v_s5;
	logic [3*POS_W-1:0]       ram_rdata;
	logic signed [POS_W-1:0]  ram_pos [3];
	logic signed [POS_W:0]    d_s2    [3];
	logic signed [59:0]       p_s3    [9];
	logic [31:0]              mag_s4  [3];
	logic [63:0]              sq_s5   [3];
	logic [63:0]              acc_q   [3];
	logic signed [61:0]       rot_sum [3];
	logic signed [41:0]       rot_rnd [3];
	logic [41:0]              rot_mag [3];

	// variance and square root
	logic [OUT_W-1:0] var_q [3];
	logic [OUT_W-1:0] std_q [3];
	logic             var_rnd, var_sat;
	logic [OUT_W-1:0] var_raw, var_fl;
	logic [SQ_W-1:0]  sr_rem_q, sr_root_q, sr_bit_q, sr_trial;
	logic             sr_ge;

	// store port
	logic             ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic             item_acc, take, drop_now;

	result_t result_q;
	logic    result_valid_q;
	logic    out_free;

	assign item_ready   = (state_q == S_LOAD);
	assign item_acc     = item_valid && item_ready;
	assign take         = item_acc && item.particle_valid && (count_q < CNT_W'(MAX_PARTICLES));
	assign drop_now     = item_acc && item.particle_valid && (count_q >= CNT_W'(MAX_PARTICLES));
	assign cnt_nxt      = count_q + CNT_W'(take);
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Write new particles at the fill count; read by the pass address otherwise.
	assign ram_we   = take;
	assign ram_addr = (state_q == S_PASS) ? rd_addr_q[ADDR_W-1:0] : count_q[ADDR_W-1:0];

	psbf_ram #(
		.WIDTH(3 * POS_W),
		.DEPTH(MAX_PARTICLES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({item.pos_x, item.pos_y, item.pos_z}),
		.rdata(ram_rdata)
	);

	assign ram_pos[0] = ram_rdata[3*POS_W-1:2*POS_W];
	assign ram_pos[1] = ram_rdata[2*POS_W-1:POS_W];
	assign ram_pos[2] = ram_rdata[POS_W-1:0];

	// Divider step: one quotient bit per cycle.
	assign div_trial = {1'b0, div_rem_q, div_num_q[DIV_W-1]} - {2'b00, div_den_q};
	assign div_ge    = !div_trial[DEN_W+1];

	// Rounded-mean numerator 2*sum + n.
	assign mean_num = {sum_q[ax_q][SUM_W-1], sum_q[ax_q], 1'b0}
	                + $signed({2'b00, SUM_W'(n_q)});
	assign mean_mag = mean_num[SUM_W+1] ? SUM_W'(0) - mean_num : mean_num;

	// Variance rounding, saturation and floor.
	assign var_rnd = {div_rem_q, 1'b0} >= {1'b0, div_den_q};
	assign var_sat = div_num_q >= DIV_W'(VAR_SAT);
	assign var_raw = var_sat ? VAR_SAT : div_num_q[OUT_W-1:0] + OUT_W'(var_rnd);
	assign var_fl  = (var_raw < VAR_FLOOR) ? VAR_FLOOR : var_raw;

	// Square root step: one result bit per cycle.
	assign sr_trial = sr_root_q + sr_bit_q;
	assign sr_ge    = sr_rem_q >= sr_trial;

	// Conjugate rotation matrix in Q28, rounded to Q20.
	// Product order: xx yy zz xy xz yz wx wy wz.
	always_comb begin
		mraw[0] = 35'sd268435456 - 35'(prod_q[1]) * 2 - 35'(prod_q[2]) * 2;
		mraw[1] = (35'(prod_q[3]) + 35'(prod_q[8])) * 2;
		mraw[2] = (35'(prod_q[4]) - 35'(prod_q[7])) * 2;
		mraw[3] = (35'(prod_q[3]) - 35'(prod_q[8])) * 2;
		mraw[4] = 35'sd268435456 - 35'(prod_q[0]) * 2 - 35'(prod_q[2]) * 2;
		mraw[5] = (35'(prod_q[5]) + 35'(prod_q[6])) * 2;
		mraw[6] = (35'(prod_q[4]) + 35'(prod_q[7])) * 2;
		mraw[7] = (35'(prod_q[5]) - 35'(prod_q[6])) * 2;
		mraw[8] = 35'sd268435456 - 35'(prod_q[0]) * 2 - 35'(prod_q[1]) * 2;
	end

	always_ff @(posedge clk) begin
		prod_q[0] <= qx_q * qx_q;
		prod_q[1] <= qy_q * qy_q;
		prod_q[2] <= qz_q * qz_q;
		prod_q[3] <= qx_q * qy_q;
		prod_q[4] <= qx_q * qz_q;
		prod_q[5] <= qy_q * qz_q;
		prod_q[6] <= qw_q * qx_q;
		prod_q[7] <= qw_q * qy_q;
		prod_q[8] <= qw_q * qz_q;
		for (int i = 0; i < 9; i++) begin
			mat_q[i] <= MAT_W'((mraw[i] + 35'sd128) >>> 8);
		end
	end

	// Rotated offsets: round to Q16.16 and clamp the magnitude.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rot_sum[r] = 62'(p_s3[3*r]) + 62'(p_s3[3*r+1]) + 62'(p_s3[3*r+2]);
			rot_rnd[r] = 42'((rot_sum[r] + 62'sd524288) >>> 20);
			rot_mag[r] = rot_rnd[r][41] ? 42'd0 - rot_rnd[r] : rot_rnd[r];
		end
	end

	// Pass datapath, no reset needed on payload.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d_s2[k] <= (POS_W+1)'(ram_pos[k]) - (POS_W+1)'(mean_q[k]);
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				p_s3[3*r+c] <= mat_q[3*r+c] * d_s2[c];
			end
			mag_s4[r] <= (rot_mag[r] > 42'hFFFF_FFFF) ? 32'hFFFF_FFFF : rot_mag[r][31:0];
			sq_s5[r]  <= 64'(mag_s4[r]) * 64'(mag_s4[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			count_q        <= '0;
			dropped_q      <= 1'b0;
			n_q            <= '0;
			ovf_q          <= 1'b0;
			ax_q           <= '0;
			rd_addr_q      <= '0;
			rd_v_q         <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			result_valid_q <= 1'b0;
			div_cnt_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= '0;
			end
		end else begin
			rd_v_q <= (state_q == S_PASS);
			v_s2   <= rd_v_q;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;

			// accumulate squares with saturation
			if (v_s5) begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= (65'(acc_q[k]) + 65'(sq_s5[k]) > 65'(64'hFFFF_FFFF_FFFF_FFFF))
					          ? 64'hFFFF_FFFF_FFFF_FFFF : acc_q[k] + sq_s5[k];
				end
			end

			// raise valid when the batch result is posted, drop it once taken
			if (state_q == S_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (take) begin
						sum_q[0] <= sum_q[0] + SUM_W'(item.pos_x);
						sum_q[1] <= sum_q[1] + SUM_W'(item.pos_y);
						sum_q[2] <= sum_q[2] + SUM_W'(item.pos_z);
					end
					if (item_acc && item.batch_last) begin
						n_q       <= cnt_nxt;
						ovf_q     <= dropped_q || drop_now;
						count_q   <= '0;
						dropped_q <= 1'b0;
						qw_q      <= item.quat_w;
						qx_q      <= item.quat_x;
						qy_q      <= item.quat_y;
						qz_q      <= item.quat_z;
						ax_q      <= '0;
						state_q   <= (cnt_nxt == '0) ? S_DONE : S_MSET;
					end else begin
						if (take) begin
							count_q <= cnt_nxt;
						end
						if (drop_now) begin
							dropped_q <= 1'b1;
						end
					end
				end
				S_MSET: begin
					div_num_q <= DIV_W'(mean_mag);
					div_neg_q <= mean_num[SUM_W+1];
					div_den_q <= DEN_W'({n_q, 1'b0});
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= S_MEAN;
				end
				S_MEAN, S_VAR: begin
					div_num_q <= {div_num_q[DIV_W-2:0], div_ge};
					div_rem_q <= div_ge ? div_trial[DEN_W-1:0]
					                    : {div_rem_q[DEN_W-2:0], div_num_q[DIV_W-1]};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd63) begin
						state_q <= (state_q == S_MEAN) ? S_MFIN : S_VFIN;
					end
				end
				S_MFIN: begin
					// floor of a negative quotient: negate and step down on a remainder
					mean_q[ax_q] <= div_neg_q ? ~div_num_q[POS_W-1:0] + POS_W'(div_rem_q == '0)
					                          : div_num_q[POS_W-1:0];
					if (ax_q == 2'd2) begin
						ax_q      <= '0;
						rd_addr_q <= '0;
						for (int k = 0; k < 3; k++) begin
							acc_q[k] <= '0;
						end
						state_q <= S_PASS;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_MSET;
					end
				end
				S_PASS: begin
					rd_addr_q <= rd_addr_q + CNT_W'(1);
					if (rd_addr_q == n_q - CNT_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!(rd_v_q || v_s2 || v_s3 || v_s4 || v_s5)) begin
						state_q <= S_VSET;
					end
				end
				S_VSET: begin
					div_num_q <= acc_q[ax_q];
					div_den_q <= DEN_W'({n_q, 16'h0000});
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= S_VAR;
				end
				S_VFIN: begin
					var_q[ax_q] <= var_fl;
					sr_rem_q    <= SQ_W'({var_fl, 16'h0000});
					sr_root_q   <= '0;
					sr_bit_q    <= SQ_W'(1) << (SQ_W - 2);
					state_q     <= S_SQRT;
				end
				S_SQRT: begin
					if (sr_ge) begin
						sr_rem_q  <= sr_rem_q - sr_trial;
						sr_root_q <= (sr_root_q >> 1) + sr_bit_q;
					end else begin
						sr_root_q <= sr_root_q >> 1;
					end
					sr_bit_q <= sr_bit_q >> 2;
					if (sr_bit_q[0]) begin
						state_q <= S_SFIN;
					end
				end
				S_SFIN: begin
					// round to nearest: remainder above the root means round up
					std_q[ax_q] <= OUT_W'(sr_root_q + SQ_W'(sr_rem_q > sr_root_q));
					if (ax_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_VSET;
					end
				end
				S_DONE: begin
					// hold until the result register is free, then clear the batch
					if (out_free) begin
						for (int k = 0; k < 3; k++) begin
							sum_q[k] <= '0;
						end
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			result_q.particle_count <= n_q;
			result_q.overflow       <= ovf_q;
			if (n_q == '0) begin
				result_q.std_x <= '0;
				result_q.std_y <= '0;
				result_q.std_z <= '0;
				result_q.var_x <= '0;
				result_q.var_y <= '0;
				result_q.var_z <= '0;
			end else begin
				result_q.std_x <= std_q[0];
				result_q.std_y <= std_q[1];
				result_q.std_z <= std_q[2];
				result_q.var_x <= var_q[0];
				result_q.var_y <= var_q[1];
				result_q.var_z <= var_q[2];
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PARTICLES))
		else $error("fill count beyond store depth");

	a_pass_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !(rd_v_q || v_s2 || v_s3 || v_s4 || v_s5))
		else $error("pass pipeline busy while loading");

	a_read_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_q |-> $past(state_q == S_PASS))
		else $error("store read outside the pass");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |-> (result.particle_count == CNT_W'(MAX_PARTICLES)))
		else $error("overflow flagged on a batch that was not full");

	a_var_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.particle_count != '0) |-> (result.var_x >= VAR_FLOOR))
		else $error("variance below floor");
`endif
endmodule

### tb/sv/tb_particle_spread_in_body_frame.sv
// Testbench for the particle spread block: batches of positions, checked against a predictor.
`timescale 1ns / 1ps
module tb_particle_spread_in_body_frame;
	import psbf_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	particle_spread_in_body_frame dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// Predictor state: a copy of the batch as the block should hold it.
	longint  batch_x[MAX_PARTICLES];
	longint  batch_y[MAX_PARTICLES];
	longint  batch_z[MAX_PARTICLES];
	longint  run_sum[3];
	int      batch_n;
	bit      batch_dropped;
	result_t spread_q[$];

	int errors;
	int mismatches;
	int items_sent;
	int results_seen;
	int batches_sent;
	int overflow_batches;
	int max_burst;
	int burst_left;

	// floor(v / 2^s)
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint floor_div(longint v, longint d);
		longint q;
		q = v / d;
		if (v % d != 0 && v < 0)
			q--;
		return q;
	endfunction

	// Round-to-nearest integer square root, ties up.
	function automatic longint unsigned root_nearest(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd4294967295;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (lo * lo + lo < v)
			lo++;
		return lo;
	endfunction

	function automatic longint unsigned add_square(longint unsigned acc, longint v);
		longint unsigned mag, sq;
		mag = v < 0 ? -v : v;
		if (mag > 64'hFFFF_FFFF)
			mag = 64'hFFFF_FFFF;
		sq = mag * mag;
		return (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
	endfunction

	// Fold one accepted item into the batch; queue a spread if it closes the batch.
	task automatic predict_spread(input item_t it);
		longint        mean[3], mat[3][3], d[3], w, x, y, z, s, dn;
		longint unsigned acc[3], den, v, rem;
		result_t       r;
		if (it.particle_valid) begin
			if (batch_n < MAX_PARTICLES) begin
				batch_x[batch_n] = longint'(it.pos_x);
				batch_y[batch_n] = longint'(it.pos_y);
				batch_z[batch_n] = longint'(it.pos_z);
				run_sum[0] += longint'(it.pos_x);
				run_sum[1] += longint'(it.pos_y);
				run_sum[2] += longint'(it.pos_z);
				batch_n++;
			end else begin
				batch_dropped = 1;
			end
		end
		if (!it.batch_last)
			return;
		r = '0;
		r.particle_count = CNT_W'(batch_n);
		r.overflow = batch_dropped;
		if (batch_n > 0) begin
			dn = batch_n;
			for (int a = 0; a < 3; a++)
				mean[a] = floor_div(2 * run_sum[a] + dn, 2 * dn);
			w = longint'(it.quat_w);
			x = longint'(it.quat_x);
			y = longint'(it.quat_y);
			z = longint'(it.quat_z);
			mat[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
			mat[0][1] = 2 * (x * y + w * z);
			mat[0][2] = 2 * (x * z - w * y);
			mat[1][0] = 2 * (x * y - w * z);
			mat[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
			mat[1][2] = 2 * (y * z + w * x);
			mat[2][0] = 2 * (x * z + w * y);
			mat[2][1] = 2 * (y * z - w * x);
			mat[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mat[i][j] = floor_shift(mat[i][j] + 128, 8);
			acc = '{0, 0, 0};
			for (int p = 0; p < batch_n; p++) begin
				d[0] = batch_x[p] - mean[0];
				d[1] = batch_y[p] - mean[1];
				d[2] = batch_z[p] - mean[2];
				for (int i = 0; i < 3; i++) begin
					s = mat[i][0] * d[0] + mat[i][1] * d[1] + mat[i][2] * d[2];
					acc[i] = add_square(acc[i], floor_shift(s + (64'sd1 <<< 19), 20));
				end
			end
			for (int i = 0; i < 3; i++) begin
				den = longint'(batch_n) << 16;
				v = acc[i] / den;
				rem = acc[i] % den;
				if (rem * 2 >= den)
					v++;
				if (v > 64'h7FFF_FFFF)
					v = 64'h7FFF_FFFF;
				if (v < 7)
					v = 7;
				case (i)
					0: begin
						r.var_x = OUT_W'(v);
						r.std_x = OUT_W'(root_nearest(v << 16));
					end
					1: begin
						r.var_y = OUT_W'(v);
						r.std_y = OUT_W'(root_nearest(v << 16));
					end
					default: begin
						r.var_z = OUT_W'(v);
						r.std_z = OUT_W'(root_nearest(v << 16));
					end
				endcase
			end
		end
		spread_q.push_back(r);
		run_sum = '{0, 0, 0};
		batch_n = 0;
		batch_dropped = 0;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Limit: generous fixed bound on the whole run.
	initial begin
		#80ms;
		$display("FAIL particle_spread_in_body_frame");
		$finish;
	end

	// Send one item, honoring the burst/gap pattern of the sender.
	task automatic send_item(input item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, max_burst);
			// Gap only between bursts, and not before every one; a large burst cap gives long steady streams.
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		burst_left--;
		item_valid = 1'b1;
		item = it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		// The predictor sees the item at the same edge the block accepts it.
		predict_spread(it);
		items_sent++;
		if (it.batch_last)
			batches_sent++;
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	// Hold the sender until every expected result has drained.
	task automatic drain_results();
		int guard;
		guard = 0;
		while (spread_q.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	function automatic item_t particle(input logic [31:0] px, py, pz, input bit last);
		item_t it;
		it = '0;
		it.particle_valid = 1'b1;
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		it.quat_w = 16'sd16384;
		it.batch_last = last;
		return it;
	endfunction

	function automatic logic [15:0] rand_quat_part();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [31:0] rand_pos(input int spread);
		case (spread)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 65536 * 50)) - 65536 * 50);
			default: return 32'($signed($urandom_range(0, 200)) - 100);
		endcase
	endfunction

	// Close a batch with a given quaternion, with or without a particle.
	task automatic close_batch(input logic [15:0] qw, qx, qy, qz, input bit with_particle,
		input int spread);
		item_t it;
		it = particle(rand_pos(spread), rand_pos(spread), rand_pos(spread), 1'b1);
		it.particle_valid = with_particle;
		it.quat_w = qw;
		it.quat_x = qx;
		it.quat_y = qy;
		it.quat_z = qz;
		send_item(it);
	endtask

	task automatic test_directed_extremes();
		item_t it;
		// Empty batch: only a last item with no particle.
		close_batch(16'sd16384, 16'd0, 16'd0, 16'd0, 1'b0, 2);
		// Single particle at extremes, identity rotation.
		send_item(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1));
		// An extreme particle with a random one, then two at opposite extremes: variance saturates.
		send_item(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
		close_batch(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1, 0);
		send_item(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		send_item(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
		close_batch(-16'sd16384, -16'sd16384, 16'sd0, 16'sd16384, 1'b0, 0);
		// Idle items in the middle of a batch change nothing.
		it = '1;
		it.particle_valid = 1'b0;
		it.batch_last = 1'b0;
		send_item(it);
		send_item(particle(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b0));
		send_item(it);
		// Out-of-range quaternion parts, used as given.
		close_batch(16'h8000, 16'h7FFF, 16'hC000, 16'h4001, 1'b1, 1);
		// Tiny spread: variance floor.
		send_item(particle(32'd5, 32'd5, 32'd5, 1'b0));
		close_batch(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 1'b1, 2);
	endtask

	task automatic test_store_overflow();
		// Fill the store exactly, then overrun it twice.
		for (int k = 0; k < MAX_PARTICLES; k++)
			send_item(particle(rand_pos(1), rand_pos(1), rand_pos(1), 1'b0));
		send_item(particle(rand_pos(1), rand_pos(1), rand_pos(1), 1'b0));
		close_batch(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
			1'b1, 1);
		overflow_batches++;
		drain_results();
	endtask

	task automatic test_random_batches(input int budget);
		int   n, spread;
		item_t it;
		while (items_sent < budget) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
			spread = $urandom_range(0, 2);
			max_burst = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 8);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					// Noise: an item with nothing in it.
					it = item_t'({2'b00, $urandom, $urandom, $urandom, $urandom, $urandom});
					it.particle_valid = 1'b0;
					it.batch_last = 1'b0;
					send_item(it);
				end
				send_item(particle(rand_pos(spread), rand_pos(spread), rand_pos(spread), 1'b0));
			end
			close_batch(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
				$urandom_range(0, 1), spread);
			if ($urandom_range(0, 15) == 0)
				drain_results();
		end
	endtask

	// Receiver: stall on its own pattern of stall and flow stretches.
	initial begin
		int mode, runlen;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			runlen = $urandom_range(1, 40);
			repeat (runlen) begin
				@(negedge clk);
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= ($urandom_range(0, 1) == 1);
					2: result_ready <= ($urandom_range(0, 4) == 0);
					default: result_ready <= 1'b0;
				endcase
			end
		end
	end

	// Check each accepted result against the oldest expected spread.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (spread_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", result);
			end else begin
				exp_r = spread_q.pop_front();
				if (result !== exp_r) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_r, result);
				end
			end
		end
	end

	initial begin
		int guard;
		errors = 0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		batches_sent = 0;
		overflow_batches = 0;
		burst_left = 0;
		max_burst = 4;
		batch_n = 0;
		batch_dropped = 0;
		run_sum = '{0, 0, 0};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_extremes();
		drain_results();
		test_store_overflow();
		test_random_batches(1650);

		guard = 0;
		while (spread_q.size() != 0 && guard < 500000) begin
			@(negedge clk);
			guard++;
		end
		if (spread_q.size() != 0) begin
			$display("FAIL particle_spread_in_body_frame");
			$finish;
		end
		repeat (600) @(negedge clk);
		$display("Covered %0d items in %0d batches (%0d overrun the store), %0d results.",
			items_sent, batches_sent, overflow_batches, results_seen);
		if (errors == 0)
			$display("PASS particle_spread_in_body_frame");
		else
			$display("FAIL particle_spread_in_body_frame");
		$finish;
	end
endmodule

### particle_spread_in_body_frame.f
rtl/psbf_pkg.sv
rtl/psbf_ram.sv
rtl/particle_spread_in_body_frame.sv
tb/sv/tb_particle_spread_in_body_frame.sv
